// ===== design/tcae_pkg.sv =====
// ----------------------------------------------------------------------------
// tcae_pkg
// Shared types, constants and helpers for the text cell to ANSI encoder.
// ----------------------------------------------------------------------------
package tcae_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] ColumnsReset = 8'd80;
  localparam logic       NewlineReset = 1'b1;

  localparam logic [7:0] ByteEsc     = 8'h1b;
  localparam logic [7:0] ByteBracket = 8'h5b;
  localparam logic [7:0] ByteOne     = 8'h31;
  localparam logic [7:0] ByteSemi    = 8'h3b;
  localparam logic [7:0] ByteZero    = 8'h30;
  localparam logic [7:0] ByteM       = 8'h6d;
  localparam logic [7:0] ByteLf      = 8'h0a;
  localparam logic [7:0] ByteFgTens  = 8'h33;
  localparam logic [7:0] ByteBgTens  = 8'h34;

  localparam logic [0:0] RegColumns = 1'b0;
  localparam logic [0:0] RegNewline = 1'b1;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       screen_end;
  } cell_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
    logic       color;
    logic       row_nl;
    logic       scr_end;
    logic       nl_en;
  } cmd_t;

  function automatic logic [7:0] ansi_digit(input logic [2:0] c);
    logic [7:0] d;
    case (c)
      3'd0: d = 8'h30;
      3'd1: d = 8'h34;
      3'd2: d = 8'h32;
      3'd3: d = 8'h36;
      3'd4: d = 8'h31;
      3'd5: d = 8'h35;
      3'd6: d = 8'h33;
      default: d = 8'h37;
    endcase
    return d;
  endfunction

endpackage

// ===== design/tcae_front.sv =====
// ----------------------------------------------------------------------------
// tcae_front
// Accepts cells, tracks attribute and column, and issues byte commands.
// ----------------------------------------------------------------------------
module tcae_front import tcae_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] columns_i,
  input  logic       newline_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cell_t      in_word_i,
  output logic       push_o,
  output cmd_t       cmd_o,
  input  logic       full_i
);

  logic [7:0] attr_q, attr_d;
  logic [7:0] col_q, col_d;
  logic [7:0] col_next;
  logic       row_hit;
  logic       color;
  logic       row_nl;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    color    = in_word_i.cell_attr != attr_q;
    col_next = col_q + 8'd1;
    row_hit  = col_next == columns_i;
    row_nl   = row_hit && newline_i;
    attr_d   = in_word_i.cell_attr;
    col_d    = row_hit ? 8'd0 : col_next;
    if (row_nl) begin
      attr_d = 8'd0;
    end
    if (in_word_i.screen_end) begin
      attr_d = 8'd0;
      col_d  = 8'd0;
    end
    cmd_o.ch      = in_word_i.cell_char;
    cmd_o.fg      = in_word_i.cell_attr[3:0];
    cmd_o.bg      = in_word_i.cell_attr[7:4];
    cmd_o.color   = color;
    cmd_o.row_nl  = row_nl;
    cmd_o.scr_end = in_word_i.screen_end;
    cmd_o.nl_en   = newline_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= 8'd0;
      col_q  <= 8'd0;
    end else if (push_o) begin
      attr_q <= attr_d;
      col_q  <= col_d;
    end
  end

endmodule

// ===== design/tcae_queue.sv =====
// ----------------------------------------------------------------------------
// tcae_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module tcae_queue import tcae_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          mem_q [DEPTH];
  logic [AW:0]   wptr_q, rptr_q;
  logic [AW:0]   count;

  assign count   = (wptr_q[AW] == rptr_q[AW]) ?
                   {1'b0, wptr_q[AW-1:0]} - {1'b0, rptr_q[AW-1:0]} :
                   {1'b0, wptr_q[AW-1:0]} + (AW+1)'(DEPTH) - {1'b0, rptr_q[AW-1:0]};
  assign full_o  = count == (AW+1)'(DEPTH);
  assign valid_o = count != '0;
  assign head_o  = mem_q[rptr_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q[AW-1:0]] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q[AW-1:0] == AW'(DEPTH - 1)) ?
                  {~wptr_q[AW], {AW{1'b0}}} : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q[AW-1:0] == AW'(DEPTH - 1)) ?
                  {~rptr_q[AW], {AW{1'b0}}} : rptr_q + 1'b1;
      end
    end
  end

endmodule

// ===== design/tcae_back.sv =====
// ----------------------------------------------------------------------------
// tcae_back
// Byte sequencer: expands each command into escapes, character and trailer.
// ----------------------------------------------------------------------------
module tcae_back import tcae_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_head_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_word_o
);

  localparam logic [2:0] PH_FG   = 3'd0;
  localparam logic [2:0] PH_BG   = 3'd1;
  localparam logic [2:0] PH_CHAR = 3'd2;
  localparam logic [2:0] PH_ROW  = 3'd3;
  localparam logic [2:0] PH_END  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  logic       busy_q;
  logic [2:0] phase_q;
  logic [2:0] idx_q;
  cmd_t       cmd_q;
  logic       out_valid_q;
  out_t       out_q;

  cmd_t       cur;
  logic [2:0] cur_ph, cur_idx, seg_len, nxt_ph;
  logic       active, emit, seg_last, done;
  logic [7:0] byte_val;
  logic [3:0] nib;
  logic [7:0] tens;

  function automatic logic [7:0] color_byte(input logic [3:0] n, input logic [7:0] t,
                                             input logic [2:0] i);
    logic [7:0] b;
    logic [2:0] j;
    j = n[3] ? i : i + 3'd2;
    case (j)
      3'd0: b = ByteEsc;
      3'd1: b = ByteBracket;
      3'd2: b = n[3] ? ByteOne : ByteEsc;
      3'd3: b = n[3] ? ByteSemi : ByteBracket;
      3'd4: b = t;
      3'd5: b = ansi_digit(n[2:0]);
      default: b = ByteM;
    endcase
    return b;
  endfunction

  always_comb begin
    cur     = busy_q ? cmd_q : q_head_i;
    cur_ph  = busy_q ? phase_q : (q_head_i.color ? PH_FG : PH_CHAR);
    cur_idx = busy_q ? idx_q : 3'd0;
    active  = busy_q || q_valid_i;
    emit    = active && (!out_valid_q || out_ready_i);
    nib     = (cur_ph == PH_FG) ? cur.fg : cur.bg;
    tens    = (cur_ph == PH_FG) ? ByteFgTens : ByteBgTens;
    case (cur_ph)
      PH_FG, PH_BG: begin
        seg_len  = nib[3] ? 3'd7 : 3'd5;
        byte_val = color_byte(nib, tens, cur_idx);
      end
      PH_CHAR: begin
        seg_len  = 3'd1;
        byte_val = cur.ch;
      end
      PH_ROW, PH_END: begin
        seg_len = ((cur_ph == PH_ROW) || cur.nl_en) ? 3'd5 : 3'd4;
        case (cur_idx)
          3'd0: byte_val = ByteEsc;
          3'd1: byte_val = ByteBracket;
          3'd2: byte_val = ByteZero;
          3'd3: byte_val = ByteM;
          default: byte_val = ByteLf;
        endcase
      end
      default: begin
        seg_len  = 3'd1;
        byte_val = cur.ch;
      end
    endcase
    case (cur_ph)
      PH_FG:   nxt_ph = PH_BG;
      PH_BG:   nxt_ph = PH_CHAR;
      PH_CHAR: nxt_ph = cur.row_nl ? PH_ROW : (cur.scr_end ? PH_END : PH_DONE);
      PH_ROW:  nxt_ph = cur.scr_end ? PH_END : PH_DONE;
      default: nxt_ph = PH_DONE;
    endcase
    seg_last = cur_idx == seg_len - 3'd1;
    done     = seg_last && (nxt_ph == PH_DONE);
  end

  assign q_pop_o     = emit && !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte    <= byte_val;
      out_q.last_of_run <= done;
    end
    if (q_pop_o) begin
      cmd_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_DONE;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        busy_q      <= !done;
        phase_q     <= seg_last ? nxt_ph : cur_ph;
        idx_q       <= seg_last ? 3'd0 : cur_idx + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== design/text_cell_to_ansi_encoder.sv =====
// ----------------------------------------------------------------------------
// text_cell_to_ansi_encoder
// Turns text-mode cells into a terminal byte stream with ANSI colour escapes.
//
//   channel  direction  handshake                    word
//   in       input      in_valid_i / in_ready_o      cell_t
//   out      output     out_valid_o / out_ready_i    out_t
//   config   input      psel/penable/pwrite, pready  32-bit registers
//
// Each cell yields 1 to 25 bytes at one byte a cycle, set by the back
// sequencer and its output register; the front takes a word every cycle
// while the command queue has room. Reset loads 80 columns and newlines on,
// with attribute and column at zero. Either side may stall on its own.
// ----------------------------------------------------------------------------
module text_cell_to_ansi_encoder import tcae_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cell_t       in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] columns_q;
  logic       newline_q;
  logic       wr_en;
  logic       push, full, pop, q_valid;
  cmd_t       push_cmd, head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= ColumnsReset;
      newline_q <= NewlineReset;
    end else if (wr_en) begin
      case (paddr[2:2])
        RegColumns: columns_q <= pwdata[7:0];
        RegNewline: newline_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2:2])
      RegColumns: prdata = {24'd0, columns_q};
      RegNewline: prdata = {31'd0, newline_q};
      default:    prdata = 32'd0;
    endcase
  end

  tcae_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .columns_i  (columns_q),
    .newline_i  (newline_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  tcae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head)
  );

  tcae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
